>>> rtl/sound_silence_detector_defines.svh
// ----------------------------------------------------------------------------
// Sound/silence detector assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef SOUND_SILENCE_DETECTOR_DEFINES_SVH
`define SOUND_SILENCE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Sound/silence detector package
// Widths, register codes, reset values and state types of the detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Field widths.
  localparam int PowerW    = 16;
  localparam int StepW     = 16;
  localparam int LevelW    = 16;
  localparam int LastingW  = 24;
  localparam int ElapsedW  = 24;
  localparam int CmpW      = (ElapsedW > LastingW) ? ElapsedW : LastingW;

  // Stream payload widths.
  localparam int InDataW    = 2 * PowerW;
  localparam int OutFieldsW = 2 + 1 + LevelW + PowerW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = LastingW;

  // Divider: product magnitude over threshold.
  localparam int DivNumW = 2 * PowerW;
  localparam int DivDenW = PowerW;
  localparam int DivCntW = $clog2(DivNumW);

  // Signed width of integrator plus step before clamping.
  localparam int SumW = DivNumW + 1;

  // Register reset values.
  localparam logic [PowerW-1:0]          ThresholdRst  = 16'd16384;
  localparam logic signed [StepW-1:0]    SoundStepRst  = 16'sd100;
  localparam logic signed [StepW-1:0]    SilStepRst    = -16'sd100;
  localparam logic signed [LevelW-1:0]   IntegMinRst   = 16'sd0;
  localparam logic signed [LevelW-1:0]   IntegMaxRst   = 16'sd1000;
  localparam logic signed [LevelW-1:0]   SoundOnRst    = 16'sd800;
  localparam logic signed [LevelW-1:0]   SilenceOnRst  = 16'sd200;
  localparam logic [LastingW-1:0]        LastingRst    = 24'd120000;

  // Register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SOUND_STEP = 3'd1,
    REG_SIL_STEP   = 3'd2,
    REG_INTEG_MIN  = 3'd3,
    REG_INTEG_MAX  = 3'd4,
    REG_SOUND_ON   = 3'd5,
    REG_SILENCE_ON = 3'd6,
    REG_LASTING    = 3'd7
  } cfg_idx_e;

  // Detector modes.
  typedef enum logic [1:0] {
    MODE_SILENCE = 2'd0,
    MODE_SOUND   = 2'd1,
    MODE_LASTING = 2'd2
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_START,
    SEQ_DIV,
    SEQ_CLAMP,
    SEQ_FINISH
  } seq_e;

endpackage

>>> rtl/ssd_div.sv
// ----------------------------------------------------------------------------
// Sound/silence detector divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "sound_silence_detector_defines.svh"

module ssd_div
  import ssd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DivDenW-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DivNumW-1:0] quotient_o
);

  logic [DivDenW:0]   rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  // One shift-and-subtract step on the partial remainder.
  assign trial = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = DivCntW'(DivNumW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      quo_d = {quo_q[DivNumW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `SSD_ASSERT_NXT(a_div_starts, start_i && !busy_q, busy_q, "divider did not start")
  `SSD_ASSERT_NXT(a_div_ends, busy_q && (cnt_q == '0), done_q && !busy_q,
                  "divider did not finish after its last step")
  `SSD_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while still busy")

endmodule

>>> rtl/sound_silence_detector.sv
// ----------------------------------------------------------------------------
// Sound/silence detector
// Averages channel power, moves a clamped integrator by a proportional step
// and tracks silence, sound and lasting silence with hysteresis.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tdata: right_power, left_power; tuser: req_type
//  m_axis    out  tdata: detect_state, state_changed, integrator_level, mean_power
//  cfg       in   write enable, register index, write data
//
//  A power sample passes the MUL, START, DIV (32-step divider for the proportional
//  step), CLAMP and FINISH states before the next ready; a tick goes straight to
//  FINISH. One item is worked on at a time; the result register lets the next item
//  be accepted while the previous result waits on m_axis_tready.
//  Reset is asynchronous and active low; the block is ready right after it.
// ----------------------------------------------------------------------------
`include "sound_silence_detector_defines.svh"

module sound_silence_detector
  import ssd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] right_power, [31:16] left_power
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] detect_state, [2] state_changed, [18:3] integrator_level,
  // [34:19] mean_power, [39:35] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [PowerW-1:0]        thr_q;
  logic signed [StepW-1:0]  sound_step_q, sil_step_q;
  logic signed [LevelW-1:0] integ_min_q, integ_max_q, sound_on_q, silence_on_q;
  logic [LastingW-1:0]      lasting_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= ThresholdRst;
      sound_step_q <= SoundStepRst;
      sil_step_q   <= SilStepRst;
      integ_min_q  <= IntegMinRst;
      integ_max_q  <= IntegMaxRst;
      sound_on_q   <= SoundOnRst;
      silence_on_q <= SilenceOnRst;
      lasting_q    <= LastingRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_THRESHOLD:  thr_q        <= cfg_data_i[PowerW-1:0];
        REG_SOUND_STEP: sound_step_q <= cfg_data_i[StepW-1:0];
        REG_SIL_STEP:   sil_step_q   <= cfg_data_i[StepW-1:0];
        REG_INTEG_MIN:  integ_min_q  <= cfg_data_i[LevelW-1:0];
        REG_INTEG_MAX:  integ_max_q  <= cfg_data_i[LevelW-1:0];
        REG_SOUND_ON:   sound_on_q   <= cfg_data_i[LevelW-1:0];
        REG_SILENCE_ON: silence_on_q <= cfg_data_i[LevelW-1:0];
        REG_LASTING:    lasting_q    <= cfg_data_i[LastingW-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer and detector state.
  seq_e                     state_q, state_d;
  mode_e                    mode_q, mode_d;
  logic signed [LevelW-1:0] integ_q, integ_d;
  logic [ElapsedW-1:0]      elapsed_q, elapsed_d;
  logic [PowerW-1:0]        last_mean_q, last_mean_d;
  logic                     m_valid_q, m_valid_d;

  // Per-item payload registers.
  logic                     is_tick_q, is_tick_d;
  logic [DivNumW-1:0]       prod_q, prod_d;
  logic                     neg_q, neg_d;
  logic [OutDataW-1:0]      m_data_q, m_data_d;

  // Divider interface.
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [DivNumW-1:0]       div_quo;

  // Combinational datapath terms.
  logic [PowerW-1:0]        thr_eff;
  logic [PowerW:0]          power_sum;
  logic                     at_or_above;
  logic [PowerW-1:0]        diff;
  logic signed [StepW-1:0]  step_sel;
  logic [StepW-1:0]         step_mag;
  logic signed [SumW-1:0]   delta, sum, lo_clamped, hi_clamped;
  logic                     can_load;
  logic                     out_load;

  // A zero threshold acts as one.
  assign thr_eff     = (thr_q == '0) ? PowerW'(1) : thr_q;
  assign power_sum   = {1'b0, s_axis_tdata[PowerW-1:0]} + {1'b0, s_axis_tdata[InDataW-1:PowerW]};

  // Distance from the threshold and the magnitude of the chosen step.
  assign at_or_above = (last_mean_q >= thr_eff);
  assign diff        = at_or_above ? (last_mean_q - thr_eff) : (thr_eff - last_mean_q);
  assign step_sel    = at_or_above ? sound_step_q : sil_step_q;
  assign step_mag    = step_sel[StepW-1] ? StepW'(-step_sel) : StepW'(step_sel);

  // Integrator update with the lower clamp first and the upper clamp last.
  assign delta      = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign sum        = SumW'(integ_q) + delta;
  assign lo_clamped = (sum < SumW'(integ_min_q)) ? SumW'(integ_min_q) : sum;
  assign hi_clamped = (lo_clamped > SumW'(integ_max_q)) ? SumW'(integ_max_q) : lo_clamped;

  assign can_load  = !m_valid_q || m_axis_tready;
  assign div_start = (state_q == SEQ_START);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    integ_d     = integ_q;
    elapsed_d   = elapsed_q;
    last_mean_d = last_mean_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    is_tick_d   = is_tick_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    m_data_d    = m_data_q;
    out_load    = 1'b0;

    unique case (state_q)
      SEQ_IDLE: begin
        if (s_axis_tvalid) begin
          is_tick_d = s_axis_tuser;
          if (s_axis_tuser) begin
            state_d = SEQ_FINISH;
          end else begin
            last_mean_d = power_sum[PowerW:1];
            state_d     = SEQ_MUL;
          end
        end
      end
      SEQ_MUL: begin
        prod_d  = DivNumW'(step_mag) * DivNumW'(diff);
        neg_d   = step_sel[StepW-1];
        state_d = SEQ_START;
      end
      SEQ_START: begin
        state_d = SEQ_DIV;
      end
      SEQ_DIV: begin
        if (div_done) begin
          state_d = SEQ_CLAMP;
        end
      end
      SEQ_CLAMP: begin
        integ_d = LevelW'(hi_clamped);
        state_d = SEQ_FINISH;
      end
      SEQ_FINISH: begin
        if (can_load) begin
          out_load = 1'b1;
          if (is_tick_q) begin
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + 1'b1;
            end
          end else begin
            priority if ((mode_q == MODE_SILENCE || mode_q == MODE_LASTING) &&
                         integ_q >= sound_on_q) begin
              mode_d = MODE_SOUND;
            end else if (mode_q == MODE_SOUND && integ_q <= silence_on_q) begin
              mode_d    = MODE_SILENCE;
              elapsed_d = '0;
            end else if (mode_q == MODE_SILENCE &&
                         CmpW'(elapsed_q) >= CmpW'(lasting_q)) begin
              mode_d = MODE_LASTING;
            end else begin
              mode_d = mode_q;
            end
          end
          m_valid_d = 1'b1;
          m_data_d  = OutDataW'({last_mean_q, integ_q, (mode_d != mode_q), mode_d});
          state_d   = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  // Control and detector state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      mode_q      <= MODE_SILENCE;
      integ_q     <= '0;
      elapsed_q   <= '0;
      last_mean_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      integ_q     <= integ_d;
      elapsed_q   <= elapsed_d;
      last_mean_q <= last_mean_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    is_tick_q <= is_tick_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    m_data_q  <= m_data_d;
  end

  // Divider for the proportional step.
  ssd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (thr_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign s_axis_tready = (state_q == SEQ_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SSD_ASSERT_NXT(a_tick_short, s_axis_tvalid && s_axis_tready && s_axis_tuser,
                  state_q == SEQ_FINISH, "tick transaction did not go straight to finish")
  `SSD_ASSERT_NXT(a_changed_flag, out_load, m_data_q[2] == (mode_q != $past(mode_q)),
                  "state_changed does not match the mode update")
  `SSD_ASSERT_IMP(a_div_free, state_q == SEQ_START, !div_busy,
                  "divider started while still busy")

endmodule
